FILE: hw/rtl/b36tc_pkg.sv
package b36tc_pkg;

    // Width of the converted word; bits of the input above it are ignored
    localparam int VALUE_WIDTH = 64;

    // Word is worked on one byte per cycle, padded up to whole bytes
    localparam int CHUNK_BITS  = 8;
    localparam int NUM_CHUNKS  = (VALUE_WIDTH + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PAD_WIDTH   = NUM_CHUNKS * CHUNK_BITS;
    localparam int CHUNK_CNT_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    // Text holds a sign and at most this many digits
    localparam int MAX_DIGITS  = 13;
    localparam int DIGIT_IDX_W = $clog2(MAX_DIGITS);

    localparam int FIELD_VALUE_W = 64;
    localparam int CHAR_W        = 7;
    localparam int DIGIT_W       = 6;

    localparam logic [DIGIT_W:0]  RADIX      = 7'd36;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
    localparam logic [CHAR_W-1:0] DEC_DIGITS = 7'd10;

    typedef logic [DIGIT_W-1:0] digit_t;

    // Base-36 digit to its ASCII code: '0'-'9' then 'A'-'Z'
    function automatic logic [CHAR_W-1:0] digit_ascii(input digit_t d);
        logic [CHAR_W-1:0] d_ext;
        logic [CHAR_W-1:0] code;
        d_ext = {1'b0, d};
        if (d_ext < DEC_DIGITS)
        begin
            code = CHAR_ZERO + d_ext;
        end
        else
        begin
            code = CHAR_A + d_ext - DEC_DIGITS;
        end
        return code;
    endfunction

endpackage

FILE: hw/rtl/base36_text_converter.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+----------------------------------
// item     | item_valid / item_stall | op, value[63:0]
// char     | char_valid / char_stall | char_code[6:0], last
//
// Each of the D digits is worked out one byte of the word per cycle through a
// shared divide-by-36 step; then D characters go out, after a '-' if negative,
// most significant digit first. D is at most 13 at 64 bits.
// item_stall is high from acceptance until the last character enters the
// output register, so the next item can be taken while that character waits.
// Reset (rst_n low, asynchronous) returns the sequencer to idle and empties
// the output register. char_stall holds it and, while full, the emit state.
module base36_text_converter
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 op,
    input  logic [b36tc_pkg::FIELD_VALUE_W-1:0]  value,
    output logic                                 char_valid,
    input  logic                                 char_stall,
    output logic [b36tc_pkg::CHAR_W-1:0]         char_code,
    output logic                                 last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DIVIDE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    localparam int PW = b36tc_pkg::PAD_WIDTH;
    localparam int VW = b36tc_pkg::VALUE_WIDTH;
    localparam int CB = b36tc_pkg::CHUNK_BITS;
    localparam int IW = b36tc_pkg::DIGIT_IDX_W;
    localparam int CW = b36tc_pkg::CHUNK_CNT_W;

    logic [1:0]                      state_reg, state_next;
    logic [PW-1:0]                   quot_reg, quot_next;
    b36tc_pkg::digit_t               rem_reg, rem_next;
    logic [CW-1:0]                   chunk_reg, chunk_next;
    logic [IW-1:0]                   ndig_reg, ndig_next;
    logic [IW-1:0]                   emit_idx_reg, emit_idx_next;
    logic                            sign_reg, sign_next;
    logic                            out_valid_reg, out_valid_next;
    logic [b36tc_pkg::CHAR_W-1:0]    char_reg, char_next;
    logic                            last_reg, last_next;
    b36tc_pkg::digit_t               digits_reg [b36tc_pkg::MAX_DIGITS];

    logic                            accept;
    logic                            load_ok;
    logic                            digit_done;
    logic [VW-1:0]                   raw;
    logic [VW-1:0]                   mag;
    logic                            negative;
    logic [CB-1:0]                   step_q;
    b36tc_pkg::digit_t               step_r;
    logic [PW-1:0]                   step_quot;
    logic [IW:0]                     ndig_inc;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);
    assign load_ok    = !out_valid_reg || !char_stall;

    assign char_valid = out_valid_reg;
    assign char_code  = char_reg;
    assign last       = last_reg;

    // Input word, its sign and magnitude
    assign raw      = value[VW-1:0];
    assign negative = op && raw[VW-1];
    assign mag      = negative ? (~raw + VW'(1)) : raw;

    // Shared step: remainder and next byte through 8 restoring subtractions
    always_comb
    begin
        logic [b36tc_pkg::DIGIT_W:0] r2;
        logic [CB-1:0]               bits;
        b36tc_pkg::digit_t           r;
        logic [PW+CB-1:0]            shifted;
        r    = rem_reg;
        bits = quot_reg[PW-1 -: CB];
        for (int i = 0; i < CB; i++)
        begin
            r2 = {r, bits[CB-1-i]};
            if (r2 >= b36tc_pkg::RADIX)
            begin
                r2 = r2 - b36tc_pkg::RADIX;
                step_q[CB-1-i] = 1'b1;
            end
            else
            begin
                step_q[CB-1-i] = 1'b0;
            end
            r = r2[b36tc_pkg::DIGIT_W-1:0];
        end
        step_r    = r;
        shifted   = {quot_reg, step_q};
        step_quot = shifted[PW-1:0];
    end

    assign digit_done = (chunk_reg == CW'(b36tc_pkg::NUM_CHUNKS - 1));
    assign ndig_inc   = {1'b0, ndig_reg} + (IW+1)'(1);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        quot_next      = quot_reg;
        rem_next       = rem_reg;
        chunk_next     = chunk_reg;
        ndig_next      = ndig_reg;
        emit_idx_next  = emit_idx_reg;
        sign_next      = sign_reg;
        out_valid_next = out_valid_reg && char_stall;
        char_next      = char_reg;
        last_next      = last_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    quot_next  = PW'(mag);
                    rem_next   = '0;
                    chunk_next = '0;
                    ndig_next  = '0;
                    sign_next  = negative;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                quot_next = step_quot;
                if (digit_done)
                begin
                    rem_next   = '0;
                    chunk_next = '0;
                    ndig_next  = ndig_inc[IW-1:0];
                    // Stop on zero quotient or a full digit buffer
                    if ((step_quot == '0) ||
                        (ndig_inc == (IW+1)'(b36tc_pkg::MAX_DIGITS)))
                    begin
                        emit_idx_next = ndig_reg;
                        state_next    = ST_EMIT;
                    end
                end
                else
                begin
                    rem_next   = step_r;
                    chunk_next = chunk_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    if (sign_reg)
                    begin
                        char_next = b36tc_pkg::CHAR_MINUS;
                        last_next = 1'b0;
                        sign_next = 1'b0;
                    end
                    else
                    begin
                        char_next = b36tc_pkg::digit_ascii(digits_reg[emit_idx_reg]);
                        last_next = (emit_idx_reg == '0);
                        if (emit_idx_reg == '0)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            emit_idx_next = emit_idx_reg - IW'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        quot_reg     <= quot_next;
        rem_reg      <= rem_next;
        chunk_reg    <= chunk_next;
        ndig_reg     <= ndig_next;
        emit_idx_reg <= emit_idx_next;
        sign_reg     <= sign_next;
        char_reg     <= char_next;
        last_reg     <= last_next;
    end

    // Digit buffer, least significant digit first
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_DIVIDE) && digit_done)
        begin
            digits_reg[ndig_reg] <= step_r;
        end
    end

endmodule
